FILE: src/base64_encoder_core_macros.svh
// Assertion helpers for the file that checks internal behavior.
`ifndef BASE64_ENCODER_CORE_MACROS_SVH
`define BASE64_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the character mapping of the base64 encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] PAD_CHAR = 8'd61;

  // Number of bytes held by the packer.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // Number of real bytes in a group.
  localparam logic [1:0] GROUP_ONE   = 2'd1;
  localparam logic [1:0] GROUP_TWO   = 2'd2;
  localparam logic [1:0] GROUP_THREE = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       is_final;
  } group_t;

  typedef struct packed {
    logic   push;
    group_t group;
  } front_out_t;

  typedef struct packed {
    logic   not_empty;
    logic   full;
    group_t head;
  } queue_status_t;

  // Maps a six-bit value onto the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

endpackage

FILE: src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Byte packer: holds up to two bytes and releases a group of one to three.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  b64e_pkg::queue_status_t qstat,
  output b64e_pkg::front_out_t    fout,
  output logic [1:0]              held_level
);
  import b64e_pkg::*;

  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       emits;
  logic       accept;

  // A group leaves on the last byte or on the third byte.
  assign emits    = last_byte || !(held_count == HELD_NONE || held_count == HELD_ONE);
  assign in_ready = !emits || !qstat.full;
  assign accept   = in_valid && in_ready;
  assign held_level = held_count;

  always_comb begin
    fout.push           = accept && emits;
    fout.group.is_final = last_byte;
    held_count_next     = held_count;
    case (held_count)
      HELD_NONE: begin
        fout.group.b0     = data_byte;
        fout.group.b1     = 8'd0;
        fout.group.b2     = 8'd0;
        fout.group.nbytes = GROUP_ONE;
        if (accept && !last_byte) held_count_next = HELD_ONE;
      end
      HELD_ONE: begin
        fout.group.b0     = held_first;
        fout.group.b1     = data_byte;
        fout.group.b2     = 8'd0;
        fout.group.nbytes = GROUP_TWO;
        if (accept) held_count_next = last_byte ? HELD_NONE : HELD_TWO;
      end
      default: begin
        fout.group.b0     = held_first;
        fout.group.b1     = held_second;
        fout.group.b2     = data_byte;
        fout.group.nbytes = GROUP_THREE;
        if (accept) held_count_next = HELD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
    end else begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_byte && held_count == HELD_NONE) held_first <= data_byte;
    if (accept && !last_byte && held_count == HELD_ONE) held_second <= data_byte;
  end

endmodule

FILE: src/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the packer and the character stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  b64e_pkg::front_out_t    fout,
  input  logic                    pop,
  output b64e_pkg::queue_status_t qstat
);
  import b64e_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  group_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign qstat.head      = entries[rd_ptr];
  assign do_push = fout.push && !qstat.full;
  assign do_pop  = pop && qstat.not_empty;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop) rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= fout.group;
  end

endmodule

FILE: src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Character stage: maps a group to four characters into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64e_pkg::queue_status_t qstat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              char_first,
  output logic [7:0]              char_second,
  output logic [7:0]              char_third,
  output logic [7:0]              char_fourth,
  output logic                    group_is_final
);
  import b64e_pkg::*;

  logic [23:0] bits;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic [7:0]  c2;
  logic [7:0]  c3;

  assign pop  = qstat.not_empty && (!out_valid || out_ready);
  assign bits = {qstat.head.b0, qstat.head.b1, qstat.head.b2};

  always_comb begin
    c0 = sextet_char(bits[23:18]);
    c1 = sextet_char(bits[17:12]);
    c2 = (qstat.head.nbytes == GROUP_ONE) ? PAD_CHAR : sextet_char(bits[11:6]);
    c3 = (qstat.head.nbytes == GROUP_THREE) ? sextet_char(bits[5:0]) : PAD_CHAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_first     <= c0;
      char_second    <= c1;
      char_third     <= c2;
      char_fourth    <= c3;
      group_is_final <= qstat.head.is_final;
    end
  end

endmodule

FILE: src/base64_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_encoder_core
// Base64 encoder: raw bytes in, groups of four alphabet characters out.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+----------------------
//  input    | in_valid, in_ready, data_byte, last_byte   | one raw byte
//  output   | out_valid, out_ready, char_first..fourth,  | one group of four
//           | group_is_final                             | characters
//
// One byte is taken per cycle while in_ready is high; when its third or last
// byte is taken, a group goes into a two-entry group queue, then the output register.
// Reset clears the held-byte count, the queue and the output valid flag.
// A stalled output fills the queue; bytes that complete a group then wait,
// while bytes that are only held are still taken.
`timescale 1ns / 1ps
`include "base64_encoder_core_macros.svh"

module base64_encoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_first,
  output logic [7:0] char_second,
  output logic [7:0] char_third,
  output logic [7:0] char_fourth,
  output logic       group_is_final
);
  import b64e_pkg::*;

  front_out_t    fout;
  queue_status_t qstat;
  logic          pop;
  logic [1:0]    held_level;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .qstat      (qstat),
    .fout       (fout),
    .held_level (held_level)
  );

  b64e_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .fout  (fout),
    .pop   (pop),
    .qstat (qstat)
  );

  b64e_back u_back (
    .clk            (clk),
    .rst            (rst),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_first     (char_first),
    .char_second    (char_second),
    .char_third     (char_third),
    .char_fourth    (char_fourth),
    .group_is_final (group_is_final)
  );

  `B64E_ASSERT_NOW(a_no_overflow, clk, rst, fout.push, !qstat.full, "group pushed into full queue")
  `B64E_ASSERT_NOW(a_held_range, clk, rst, 1'b1, held_level != 2'd3, "held count out of range")
  `B64E_ASSERT_NOW(a_pad_order, clk, rst, out_valid && char_third == PAD_CHAR, char_fourth == PAD_CHAR, "third pad without fourth pad")
  `B64E_ASSERT_NEXT(a_pop_shows, clk, rst, pop, out_valid, "popped group not shown")

endmodule
